[src/word_boundary_scanner_defines.svh]
// Assertion macros shared by the word boundary scanner modules.
// Each macro samples on clock and is disabled while reset is high.
`ifndef WORD_BOUNDARY_SCANNER_DEFINES_SVH
`define WORD_BOUNDARY_SCANNER_DEFINES_SVH

// Condition holds at every clock edge
`define WBS_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define WBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define WBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[src/wbs_pkg.sv]
// Package for the word boundary scanner: break classes, word types, scan states,
// channel payload structs. No dependencies.
`timescale 1ns / 1ps

package wbs_pkg;

   localparam int unsigned LEN_BITS_DEFAULT = 16;
   localparam int unsigned MAX_PUSH         = 3;   // most words one character can finish
   localparam int unsigned RSP_DEPTH        = 4;   // result queue entries

   // Word-break classes
   localparam logic [4:0] CLS_CR   = 5'd0;
   localparam logic [4:0] CLS_LF   = 5'd1;
   localparam logic [4:0] CLS_NL   = 5'd2;
   localparam logic [4:0] CLS_ZWJ  = 5'd3;
   localparam logic [4:0] CLS_AL   = 5'd4;
   localparam logic [4:0] CLS_NUM  = 5'd5;
   localparam logic [4:0] CLS_ENL  = 5'd6;
   localparam logic [4:0] CLS_HEB  = 5'd7;
   localparam logic [4:0] CLS_KAT  = 5'd8;
   localparam logic [4:0] CLS_EB   = 5'd9;
   localparam logic [4:0] CLS_EBG  = 5'd10;
   localparam logic [4:0] CLS_RI   = 5'd11;
   localparam logic [4:0] CLS_LET  = 5'd12;
   localparam logic [4:0] CLS_NUMB = 5'd13;
   localparam logic [4:0] CLS_DQ   = 5'd14;
   localparam logic [4:0] CLS_ML   = 5'd15;
   localparam logic [4:0] CLS_MN   = 5'd16;
   localparam logic [4:0] CLS_MNL  = 5'd17;
   localparam logic [4:0] CLS_PUN  = 5'd18;
   localparam logic [4:0] CLS_SQ   = 5'd19;
   localparam logic [4:0] CLS_EMOD = 5'd20;
   localparam logic [4:0] CLS_GAZ  = 5'd21;
   localparam logic [4:0] CLS_SYM  = 5'd22;
   localparam logic [4:0] CLS_EXT  = 5'd23;
   localparam logic [4:0] CLS_MARK = 5'd24;
   localparam logic [4:0] CLS_FMT  = 5'd25;
   localparam logic [4:0] CLS_OTH  = 5'd26;
   localparam logic [4:0] CLS_WS   = 5'd27;

   // Word types
   localparam logic [2:0] KIND_SPACE  = 3'd0;
   localparam logic [2:0] KIND_OTHER  = 3'd1;
   localparam logic [2:0] KIND_SYMBOL = 3'd2;
   localparam logic [2:0] KIND_LETTER = 3'd3;
   localparam logic [2:0] KIND_NUMBER = 3'd4;
   localparam logic [2:0] KIND_PUNCT  = 3'd5;
   localparam logic [2:0] KIND_MARK   = 3'd6;

   // Scan states, one-hot
   typedef enum logic [11:0] {
      S_START = 12'b0000_0000_0001,
      S_SOLO  = 12'b0000_0000_0010,
      S_AL    = 12'b0000_0000_0100,
      S_HEB   = 12'b0000_0000_1000,
      S_NUM   = 12'b0000_0001_0000,
      S_KAT   = 12'b0000_0010_0000,
      S_ENL   = 12'b0000_0100_0000,
      S_EBASE = 12'b0000_1000_0000,
      S_RI    = 12'b0001_0000_0000,
      S_CRP   = 12'b0010_0000_0000,
      S_ZWJP  = 12'b0100_0000_0000,
      S_ENL1  = 12'b1000_0000_0000
   } scan_state_type;

   typedef struct packed {
      logic [4:0] break_class;
      logic [2:0] char_bytes;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] word_length;
      logic [2:0]  word_type;
      logic        last_word;
   } rsp_type;

   // Words finished by one accepted character, in order from item[0]
   typedef struct packed {
      logic [1:0]                count;
      rsp_type [MAX_PUSH-1:0]    item;
   } push_type;

endpackage

[src/wbs_core.sv]
// Word segmentation state machine: consumes one character per transfer and
// reports up to three finished words. Depends on wbs_pkg and the defines header.
`timescale 1ns / 1ps
`include "word_boundary_scanner_defines.svh"

module wbs_core #(
   parameter int unsigned LEN_BITS = wbs_pkg::LEN_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  wbs_pkg::req_type  req,
   output wbs_pkg::push_type push
);

   typedef struct packed {
      wbs_pkg::scan_state_type st;
      logic [2:0]              kind;
      logic                    nl;
   } start_type;

   wbs_pkg::scan_state_type st_ff, st_in;
   logic [LEN_BITS-1:0]     acc_ff, acc_in;
   logic [2:0]              kind_ff, kind_in;
   logic [4:0]              hc_ff, hc_in;
   logic [LEN_BITS-1:0]     hl_ff, hl_in;
   logic                    hv_ff, hv_in;

   logic [4:0]              cls;
   logic [LEN_BITS-1:0]     nx;
   logic                    is_ext;
   logic                    go;
   logic                    do_break;
   logic                    do_start;
   start_type               sw;
   logic [1:0]              cnt;
   logic [LEN_BITS-1:0]     e_len  [wbs_pkg::MAX_PUSH];
   logic [2:0]              e_kind [wbs_pkg::MAX_PUSH];

   function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? '1 : s[LEN_BITS-1:0];
   endfunction

   // State and type of a word opened by a character
   function automatic start_type start_info(input logic [4:0] b);
      start_type r;
      r.nl = 1'b0;
      case (b)
         wbs_pkg::CLS_CR: begin
            r.st = wbs_pkg::S_CRP;   r.kind = wbs_pkg::KIND_SPACE;
         end
         wbs_pkg::CLS_LF, wbs_pkg::CLS_NL: begin
            r.st = wbs_pkg::S_START; r.kind = wbs_pkg::KIND_SPACE; r.nl = 1'b1;
         end
         wbs_pkg::CLS_ZWJ: begin
            r.st = wbs_pkg::S_ZWJP;  r.kind = wbs_pkg::KIND_OTHER;
         end
         wbs_pkg::CLS_AL: begin
            r.st = wbs_pkg::S_AL;    r.kind = wbs_pkg::KIND_LETTER;
         end
         wbs_pkg::CLS_NUM: begin
            r.st = wbs_pkg::S_NUM;   r.kind = wbs_pkg::KIND_NUMBER;
         end
         wbs_pkg::CLS_ENL: begin
            r.st = wbs_pkg::S_ENL1;  r.kind = wbs_pkg::KIND_LETTER;
         end
         wbs_pkg::CLS_HEB: begin
            r.st = wbs_pkg::S_HEB;   r.kind = wbs_pkg::KIND_LETTER;
         end
         wbs_pkg::CLS_KAT: begin
            r.st = wbs_pkg::S_KAT;   r.kind = wbs_pkg::KIND_LETTER;
         end
         wbs_pkg::CLS_EB, wbs_pkg::CLS_EBG: begin
            r.st = wbs_pkg::S_EBASE; r.kind = wbs_pkg::KIND_SYMBOL;
         end
         wbs_pkg::CLS_RI: begin
            r.st = wbs_pkg::S_RI;    r.kind = wbs_pkg::KIND_SYMBOL;
         end
         wbs_pkg::CLS_LET: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_LETTER;
         end
         wbs_pkg::CLS_NUMB: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_NUMBER;
         end
         wbs_pkg::CLS_DQ, wbs_pkg::CLS_ML, wbs_pkg::CLS_MN, wbs_pkg::CLS_MNL,
         wbs_pkg::CLS_PUN, wbs_pkg::CLS_SQ: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_PUNCT;
         end
         wbs_pkg::CLS_EMOD, wbs_pkg::CLS_GAZ, wbs_pkg::CLS_SYM: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_SYMBOL;
         end
         wbs_pkg::CLS_EXT, wbs_pkg::CLS_MARK: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_MARK;
         end
         wbs_pkg::CLS_WS: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_SPACE;
         end
         default: begin
            r.st = wbs_pkg::S_SOLO;  r.kind = wbs_pkg::KIND_OTHER;
         end
      endcase
      return r;
   endfunction

   // Unknown classes behave as Other
   assign cls    = (req.break_class > wbs_pkg::CLS_WS) ? wbs_pkg::CLS_OTH : req.break_class;
   assign nx     = LEN_BITS'(req.char_bytes);
   assign is_ext = cls inside {wbs_pkg::CLS_EXT, wbs_pkg::CLS_FMT, wbs_pkg::CLS_ZWJ};
   assign sw     = start_info(cls);

   // One character step: next state plus the words it finishes
   always_comb begin
      st_in    = st_ff;
      acc_in   = acc_ff;
      kind_in  = kind_ff;
      hc_in    = hc_ff;
      hl_in    = hl_ff;
      hv_in    = hv_ff;
      cnt      = 2'd0;
      do_break = 1'b0;
      do_start = 1'b0;
      go       = 1'b0;
      for (int i = 0; i < wbs_pkg::MAX_PUSH; i++) begin
         e_len[i]  = '0;
         e_kind[i] = '0;
      end

      if (is_ext) begin
         // extend, format and ZWJ attach to what came before, but open a word at the start or after a CR
         if (hv_ff) begin
            hl_in = sat_add(hl_ff, nx);
         end else begin
            case (st_ff)
               wbs_pkg::S_START: do_start = 1'b1;
               wbs_pkg::S_CRP: begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
               wbs_pkg::S_ZWJP: begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_SOLO;
               end
               default: acc_in = sat_add(acc_ff, nx);
            endcase
         end
      end else if (hv_ff) begin
         // this base character decides the pending mid character
         if (st_ff == wbs_pkg::S_NUM) begin
            go = (cls == wbs_pkg::CLS_NUM);
         end else if (hc_ff == wbs_pkg::CLS_DQ) begin
            go = (cls == wbs_pkg::CLS_HEB);
         end else begin
            go = (cls == wbs_pkg::CLS_AL) || (cls == wbs_pkg::CLS_HEB);
         end
         hv_in = 1'b0;
         hl_in = '0;
         if (go) begin
            acc_in = sat_add(sat_add(acc_ff, hl_ff), nx);
            if (cls == wbs_pkg::CLS_AL) begin
               st_in = wbs_pkg::S_AL;
            end else if (cls == wbs_pkg::CLS_HEB) begin
               st_in = wbs_pkg::S_HEB;
            end else begin
               st_in = wbs_pkg::S_NUM;
            end
         end else begin
            if (st_ff == wbs_pkg::S_HEB && hc_ff == wbs_pkg::CLS_SQ) begin
               // trailing quote stays with the Hebrew word
               e_len[cnt]  = sat_add(acc_ff, hl_ff);
               e_kind[cnt] = kind_ff;
               cnt         = cnt + 2'd1;
            end else begin
               e_len[cnt]  = acc_ff;
               e_kind[cnt] = kind_ff;
               cnt         = cnt + 2'd1;
               e_len[cnt]  = hl_ff;
               e_kind[cnt] = wbs_pkg::KIND_PUNCT;
               cnt         = cnt + 2'd1;
            end
            do_start = 1'b1;
         end
      end else begin
         case (st_ff)
            wbs_pkg::S_START: do_start = 1'b1;
            wbs_pkg::S_AL, wbs_pkg::S_HEB, wbs_pkg::S_NUM: begin
               if ((st_ff == wbs_pkg::S_AL &&
                    cls inside {wbs_pkg::CLS_ML, wbs_pkg::CLS_MNL, wbs_pkg::CLS_SQ}) ||
                   (st_ff == wbs_pkg::S_HEB &&
                    cls inside {wbs_pkg::CLS_ML, wbs_pkg::CLS_MNL, wbs_pkg::CLS_SQ,
                                wbs_pkg::CLS_DQ}) ||
                   (st_ff == wbs_pkg::S_NUM &&
                    cls inside {wbs_pkg::CLS_MNL, wbs_pkg::CLS_SQ, wbs_pkg::CLS_MN})) begin
                  hv_in = 1'b1;
                  hc_in = cls;
                  hl_in = nx;
               end else if (cls == wbs_pkg::CLS_AL) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_AL;
               end else if (cls == wbs_pkg::CLS_HEB) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_HEB;
               end else if (cls == wbs_pkg::CLS_NUM) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_NUM;
               end else if (cls == wbs_pkg::CLS_ENL) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_ENL;
               end else begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
            end
            wbs_pkg::S_KAT: begin
               if (cls == wbs_pkg::CLS_KAT) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_KAT;
               end else if (cls == wbs_pkg::CLS_ENL) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_ENL;
               end else begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
            end
            wbs_pkg::S_ENL, wbs_pkg::S_ENL1: begin
               acc_in = sat_add(acc_ff, nx);
               case (cls)
                  wbs_pkg::CLS_AL:  st_in = wbs_pkg::S_AL;
                  wbs_pkg::CLS_NUM: begin
                     // a word opened by an extender turns numeric
                     if (st_ff == wbs_pkg::S_ENL1) begin
                        kind_in = wbs_pkg::KIND_NUMBER;
                     end
                     st_in = wbs_pkg::S_NUM;
                  end
                  wbs_pkg::CLS_ENL: st_in = wbs_pkg::S_ENL;
                  wbs_pkg::CLS_HEB: st_in = wbs_pkg::S_HEB;
                  wbs_pkg::CLS_KAT: st_in = wbs_pkg::S_KAT;
                  default: begin
                     acc_in   = acc_ff;
                     do_break = 1'b1;
                     do_start = 1'b1;
                  end
               endcase
            end
            wbs_pkg::S_EBASE: begin
               if (cls == wbs_pkg::CLS_EMOD) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_SOLO;
               end else begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
            end
            wbs_pkg::S_RI: begin
               if (cls == wbs_pkg::CLS_RI) begin
                  acc_in = sat_add(acc_ff, nx);
                  st_in  = wbs_pkg::S_SOLO;
               end else begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
            end
            wbs_pkg::S_CRP: begin
               if (cls == wbs_pkg::CLS_LF) begin
                  // CR LF closes as one space word
                  e_len[cnt]  = sat_add(acc_ff, nx);
                  e_kind[cnt] = wbs_pkg::KIND_SPACE;
                  cnt         = cnt + 2'd1;
                  acc_in      = '0;
                  kind_in     = wbs_pkg::KIND_SPACE;
                  st_in       = wbs_pkg::S_START;
               end else begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
            end
            wbs_pkg::S_ZWJP: begin
               if (cls == wbs_pkg::CLS_GAZ) begin
                  acc_in  = sat_add(acc_ff, nx);
                  kind_in = wbs_pkg::KIND_SYMBOL;
                  st_in   = wbs_pkg::S_SOLO;
               end else if (cls == wbs_pkg::CLS_EBG) begin
                  acc_in  = sat_add(acc_ff, nx);
                  kind_in = wbs_pkg::KIND_SYMBOL;
                  st_in   = wbs_pkg::S_EBASE;
               end else begin
                  do_break = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: begin
               do_break = 1'b1;
               do_start = 1'b1;
            end
         endcase
      end

      // close the open word
      if (do_break) begin
         e_len[cnt]  = acc_ff;
         e_kind[cnt] = kind_ff;
         cnt         = cnt + 2'd1;
      end

      // open a new word; a newline is a word on its own
      if (do_start) begin
         acc_in  = nx;
         kind_in = sw.kind;
         st_in   = sw.st;
         if (sw.nl) begin
            e_len[cnt]  = nx;
            e_kind[cnt] = wbs_pkg::KIND_SPACE;
            cnt         = cnt + 2'd1;
            acc_in      = '0;
            kind_in     = wbs_pkg::KIND_SPACE;
         end
      end

      // end of text flushes whatever is pending
      if (req.end_of_text) begin
         if (hv_in) begin
            if (st_in == wbs_pkg::S_HEB && hc_in == wbs_pkg::CLS_SQ) begin
               e_len[cnt]  = sat_add(acc_in, hl_in);
               e_kind[cnt] = kind_in;
               cnt         = cnt + 2'd1;
            end else begin
               e_len[cnt]  = acc_in;
               e_kind[cnt] = kind_in;
               cnt         = cnt + 2'd1;
               e_len[cnt]  = hl_in;
               e_kind[cnt] = wbs_pkg::KIND_PUNCT;
               cnt         = cnt + 2'd1;
            end
         end else if (st_in != wbs_pkg::S_START) begin
            e_len[cnt]  = acc_in;
            e_kind[cnt] = kind_in;
            cnt         = cnt + 2'd1;
         end
         st_in   = wbs_pkg::S_START;
         acc_in  = '0;
         kind_in = wbs_pkg::KIND_SPACE;
         hc_in   = wbs_pkg::CLS_CR;
         hl_in   = '0;
         hv_in   = 1'b0;
      end
   end

   // Finished words toward the result queue
   always_comb begin
      push.count = accept ? cnt : 2'd0;
      for (int i = 0; i < wbs_pkg::MAX_PUSH; i++) begin
         push.item[i].word_length = 16'(e_len[i]);
         push.item[i].word_type   = e_kind[i];
         push.item[i].last_word   = req.end_of_text && (cnt == 2'(i + 1));
      end
   end

   // Scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= wbs_pkg::S_START;
         acc_ff  <= '0;
         kind_ff <= wbs_pkg::KIND_SPACE;
         hc_ff   <= wbs_pkg::CLS_CR;
         hl_ff   <= '0;
         hv_ff   <= 1'b0;
      end else if (accept) begin
         st_ff   <= st_in;
         acc_ff  <= acc_in;
         kind_ff <= kind_in;
         hc_ff   <= hc_in;
         hl_ff   <= hl_in;
         hv_ff   <= hv_in;
      end
   end

   `WBS_ASSERT_SAME(a_held_in_run, hv_ff, (st_ff == wbs_pkg::S_AL || st_ff == wbs_pkg::S_HEB || st_ff == wbs_pkg::S_NUM), "mid character held outside a letter or number run")
   `WBS_ASSERT_SAME(a_start_clean, st_ff == wbs_pkg::S_START, (acc_ff == '0 && !hv_ff), "start state with open length or held character")
   `WBS_ASSERT_NEXT(a_eot_resets, accept && req.end_of_text, (st_ff == wbs_pkg::S_START && !hv_ff), "end of text did not return to start")

endmodule

[src/word_boundary_scanner.sv]
// Word boundary scanner, top level: character input channel, scan core,
// result queue. Depends on wbs_pkg, wbs_core and the defines header.
//
// Usage:
//   req_* carries one character per transfer (word-break class, byte count,
//   end-of-text flag). rsp_* carries one finished word per transfer (byte
//   length, type, last-word flag). A transfer happens on a clock edge with
//   valid high and stall low.
//   Throughput: one character per cycle while req_stall is low. A character
//   finishes zero to three words; they enter a four-entry result queue in
//   the cycle the character is taken and leave at one word per cycle while
//   rsp_stall is low, so the queue drain rate sets the sustained rate when
//   many short words arrive. A finished word is offered on rsp_valid once the
//   registered queue holds it and the words ahead of it have left.
//   req_stall is high while the queue could not take three more words.
//   A stalled receiver just fills the queue; nothing is dropped.
//   Reset (synchronous) empties the queue and returns the scanner to the
//   start of a text with nothing pending.
`timescale 1ns / 1ps
`include "word_boundary_scanner_defines.svh"

module word_boundary_scanner #(
   parameter int unsigned LEN_BITS = wbs_pkg::LEN_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wbs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wbs_pkg::rsp_type rsp_data
);

   localparam int unsigned PTR_BITS = $clog2(wbs_pkg::RSP_DEPTH);
   localparam int unsigned CNT_BITS = PTR_BITS + 1;

   wbs_pkg::push_type      push;
   logic                   accept;
   logic                   pop;
   logic [PTR_BITS-1:0]    wr_ptr_ff;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [CNT_BITS-1:0]    count_ff;
   wbs_pkg::rsp_type       mem [wbs_pkg::RSP_DEPTH];

   assign req_stall = count_ff > CNT_BITS'(wbs_pkg::RSP_DEPTH - wbs_pkg::MAX_PUSH);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = mem[rd_ptr_ff];

   wbs_core #(
      .LEN_BITS (LEN_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .push   (push)
   );

   // Result queue storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < wbs_pkg::MAX_PUSH; i++) begin
         if (i < int'(push.count)) begin
            mem[wr_ptr_ff + PTR_BITS'(i)] <= push.item[i];
         end
      end
   end

   // Result queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(push.count);
         rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(pop);
         count_ff  <= count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
      end
   end

   `WBS_ASSERT_HOLDS(a_no_overflow, count_ff <= CNT_BITS'(wbs_pkg::RSP_DEPTH), "result queue overflow")
   `WBS_ASSERT_SAME(a_push_only_on_accept, !accept, push.count == 2'd0, "words pushed without a character transfer")
   `WBS_ASSERT_NEXT(a_count_tracks, !pop, count_ff == $past(count_ff) + CNT_BITS'($past(push.count)), "queue count does not follow pushes")

endmodule

[verif/testbench.sv]
// Self-checking testbench for word_boundary_scanner: directed and random character
// streams, a behavioral word segmenter as predictor, checks of every finished word.
// Depends on wbs_pkg and the word_boundary_scanner RTL.
`timescale 1ns / 1ps

module testbench;
   import wbs_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no transfer before giving up
   localparam int DRILL_ROWS  = 26;

   typedef struct packed {
      logic [4:0]  cls;
      logic [2:0]  bytes;
      logic        eot;
      logic        typed;     // row carries its own expected word
      logic [15:0] len;
      logic [2:0]  kind;
   } drill_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   // Predictor state
   scan_state_type scan_q = S_START;
   logic [15:0]    word_acc = '0;
   logic [2:0]     word_kind_q = '0;
   logic [4:0]     held_cls = '0;
   logic [15:0]    held_bytes = '0;
   logic           held_on = 1'b0;

   rsp_type step_words[$];       // words finished by the current character
   rsp_type expected_words[$];   // words the block still owes
   req_type text_chars[$];       // character stream waiting to be sent
   drill_row_type drill_rows [DRILL_ROWS];

   word_boundary_scanner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function automatic void emit_word(logic [15:0] len, logic [2:0] kind);
      rsp_type w;
      w.word_length = len;
      w.word_type   = kind;
      w.last_word   = 1'b0;
      if (step_words.size() < MAX_PUSH) step_words.push_back(w);
   endfunction

   function automatic void open_word(logic [4:0] b, logic [15:0] n);
      word_acc = n;
      case (b)
         CLS_CR: begin word_kind_q = KIND_SPACE; scan_q = S_CRP; end
         CLS_LF, CLS_NL: begin
            emit_word(word_acc, KIND_SPACE);
            word_acc = '0; word_kind_q = '0; scan_q = S_START;
         end
         CLS_ZWJ:  begin word_kind_q = KIND_OTHER;  scan_q = S_ZWJP;  end
         CLS_AL:   begin word_kind_q = KIND_LETTER; scan_q = S_AL;    end
         CLS_NUM:  begin word_kind_q = KIND_NUMBER; scan_q = S_NUM;   end
         CLS_ENL:  begin word_kind_q = KIND_LETTER; scan_q = S_ENL1;  end
         CLS_HEB:  begin word_kind_q = KIND_LETTER; scan_q = S_HEB;   end
         CLS_KAT:  begin word_kind_q = KIND_LETTER; scan_q = S_KAT;   end
         CLS_EB, CLS_EBG: begin word_kind_q = KIND_SYMBOL; scan_q = S_EBASE; end
         CLS_RI:   begin word_kind_q = KIND_SYMBOL; scan_q = S_RI;    end
         CLS_LET:  begin word_kind_q = KIND_LETTER; scan_q = S_SOLO;  end
         CLS_NUMB: begin word_kind_q = KIND_NUMBER; scan_q = S_SOLO;  end
         CLS_DQ, CLS_ML, CLS_MN, CLS_MNL, CLS_PUN, CLS_SQ: begin
            word_kind_q = KIND_PUNCT; scan_q = S_SOLO;
         end
         CLS_EMOD, CLS_GAZ, CLS_SYM: begin word_kind_q = KIND_SYMBOL; scan_q = S_SOLO; end
         CLS_EXT, CLS_MARK: begin word_kind_q = KIND_MARK; scan_q = S_SOLO; end
         CLS_WS:   begin word_kind_q = KIND_SPACE;  scan_q = S_SOLO;  end
         default:  begin word_kind_q = KIND_OTHER;  scan_q = S_SOLO;  end
      endcase
   endfunction

   function automatic void close_and_open(logic [4:0] b, logic [15:0] n);
      emit_word(word_acc, word_kind_q);
      open_word(b, n);
   endfunction

   function automatic void join_word(logic [15:0] n, scan_state_type nxt);
      word_acc = sat_sum(word_acc, n);
      scan_q   = nxt;
   endfunction

   // Mid characters that may continue the current run
   function automatic logic mid_ok(scan_state_type st, logic [4:0] b);
      if (st == S_AL)  return b == CLS_ML || b == CLS_MNL || b == CLS_SQ;
      if (st == S_HEB) return b == CLS_ML || b == CLS_MNL || b == CLS_SQ || b == CLS_DQ;
      if (st == S_NUM) return b == CLS_MNL || b == CLS_SQ || b == CLS_MN;
      return 1'b0;
   endfunction

   // Ends a held mid character: word closes, Hebrew quote case, or failed mid
   function automatic void emit_held_words();
      if (scan_q == S_HEB && held_cls == CLS_SQ) begin
         emit_word(sat_sum(word_acc, held_bytes), word_kind_q);
      end else begin
         emit_word(word_acc, word_kind_q);
         emit_word(held_bytes, KIND_PUNCT);
      end
   endfunction

   // The base character after a held mid decides whether the word goes on
   function automatic void settle_held(logic [4:0] b, logic [15:0] n);
      logic go;
      scan_state_type nxt;
      if (scan_q == S_NUM) go = (b == CLS_NUM);
      else if (held_cls == CLS_DQ) go = (b == CLS_HEB);
      else go = (b == CLS_AL || b == CLS_HEB);
      held_on = 1'b0;
      if (go) begin
         word_acc   = sat_sum(word_acc, held_bytes);
         held_bytes = '0;
         if (b == CLS_AL) nxt = S_AL;
         else if (b == CLS_HEB) nxt = S_HEB;
         else nxt = S_NUM;
         join_word(n, nxt);
         return;
      end
      emit_held_words();
      held_bytes = '0;
      open_word(b, n);
   endfunction

   function automatic void base_char(logic [4:0] b, logic [15:0] n);
      scan_state_type st;
      st = scan_q;
      if (held_on) begin
         settle_held(b, n);
         return;
      end
      case (st)
         S_START: begin
            open_word(b, n);
            return;
         end
         S_AL, S_HEB, S_NUM: begin
            if (mid_ok(st, b)) begin
               held_on = 1'b1; held_cls = b; held_bytes = n;
               return;
            end
            if (b == CLS_AL)  begin join_word(n, S_AL);  return; end
            if (b == CLS_HEB) begin join_word(n, S_HEB); return; end
            if (b == CLS_NUM) begin join_word(n, S_NUM); return; end
            if (b == CLS_ENL) begin join_word(n, S_ENL); return; end
         end
         S_KAT: begin
            if (b == CLS_KAT) begin join_word(n, S_KAT); return; end
            if (b == CLS_ENL) begin join_word(n, S_ENL); return; end
         end
         S_ENL, S_ENL1: begin
            if (b == CLS_AL) begin join_word(n, S_AL); return; end
            if (b == CLS_NUM) begin
               // a word opened by an extender turns numeric on its first digit
               if (st == S_ENL1) word_kind_q = KIND_NUMBER;
               join_word(n, S_NUM);
               return;
            end
            if (b == CLS_ENL) begin join_word(n, S_ENL); return; end
            if (b == CLS_HEB) begin join_word(n, S_HEB); return; end
            if (b == CLS_KAT) begin join_word(n, S_KAT); return; end
         end
         S_EBASE: if (b == CLS_EMOD) begin join_word(n, S_SOLO); return; end
         S_RI:    if (b == CLS_RI) begin join_word(n, S_SOLO); return; end
         S_CRP: begin
            if (b == CLS_LF) begin
               emit_word(sat_sum(word_acc, n), KIND_SPACE);
               word_acc = '0; word_kind_q = '0; scan_q = S_START;
               return;
            end
         end
         S_ZWJP: begin
            if (b == CLS_GAZ) begin word_kind_q = KIND_SYMBOL; join_word(n, S_SOLO); return; end
            if (b == CLS_EBG) begin word_kind_q = KIND_SYMBOL; join_word(n, S_EBASE); return; end
         end
         default: ;
      endcase
      close_and_open(b, n);
   endfunction

   // Extend, Format and ZWJ attach to what came before, but open a word at the start or after a CR
   function automatic void extender_char(logic [4:0] b, logic [15:0] n);
      if (held_on) begin
         held_bytes = sat_sum(held_bytes, n);
         return;
      end
      case (scan_q)
         S_START: open_word(b, n);
         S_CRP:   close_and_open(b, n);
         S_ZWJP:  join_word(n, S_SOLO);
         default: word_acc = sat_sum(word_acc, n);
      endcase
   endfunction

   function automatic void flush_text();
      if (held_on) emit_held_words();
      else if (scan_q != S_START) emit_word(word_acc, word_kind_q);
      scan_q = S_START;
      word_acc = '0; word_kind_q = '0;
      held_cls = '0; held_bytes = '0; held_on = 1'b0;
   endfunction

   function automatic void predict_char(req_type c);
      logic [4:0]  b;
      logic [15:0] n;
      b = c.break_class;
      n = {13'd0, c.char_bytes};
      step_words.delete();
      if (b > CLS_WS) b = CLS_OTH;   // unknown classes act as Other
      if (b == CLS_EXT || b == CLS_FMT || b == CLS_ZWJ) extender_char(b, n);
      else base_char(b, n);
      if (c.end_of_text) begin
         flush_text();
         if (step_words.size() > 0) step_words[step_words.size()-1].last_word = 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [2:0] rand_bytes();
      if ($urandom_range(99) < 12) return 3'($urandom_range(7));
      return 3'($urandom_range(4, 1));
   endfunction

   // Appends one character, sometimes followed by an extend, format or ZWJ character
   function automatic void push_char(logic [4:0] cls);
      req_type c;
      c.break_class = cls;
      c.char_bytes  = rand_bytes();
      c.end_of_text = 1'b0;
      text_chars.push_back(c);
      if ($urandom_range(99) < 8) begin
         case ($urandom_range(2))
            0: c.break_class = CLS_EXT;
            1: c.break_class = CLS_FMT;
            default: c.break_class = CLS_ZWJ;
         endcase
         c.char_bytes = rand_bytes();
         text_chars.push_back(c);
      end
   endfunction

   // One well-formed piece of text, or noise now and then
   function automatic void add_fragment();
      int reps;
      int k;
      logic [4:0] cls;
      reps = $urandom_range(4, 1);
      case ($urandom_range(9))
         0, 1: begin
            for (k = 0; k < reps; k++) begin
               case ($urandom_range(4))
                  0:       cls = CLS_HEB;
                  1:       cls = CLS_NUM;
                  2:       cls = CLS_ENL;
                  default: cls = CLS_AL;
               endcase
               push_char(cls);
               if ($urandom_range(99) < 35) begin
                  case ($urandom_range(3))
                     0:       cls = CLS_ML;
                     1:       cls = CLS_MNL;
                     2:       cls = CLS_SQ;
                     default: cls = CLS_DQ;
                  endcase
                  push_char(cls);
               end
            end
         end
         2: begin
            for (k = 0; k < reps; k++) begin
               case ($urandom_range(4))
                  0:       cls = CLS_ENL;
                  1:       cls = CLS_AL;
                  default: cls = CLS_NUM;
               endcase
               push_char(cls);
               if ($urandom_range(99) < 35) begin
                  case ($urandom_range(2))
                     0:       cls = CLS_MN;
                     1:       cls = CLS_MNL;
                     default: cls = CLS_SQ;
                  endcase
                  push_char(cls);
               end
            end
         end
         3: begin
            for (k = 0; k < reps; k++) push_char($urandom_range(2) == 0 ? CLS_ENL : CLS_KAT);
         end
         4: begin
            case ($urandom_range(3))
               0: begin push_char(CLS_EB); if ($urandom_range(1)) push_char(CLS_EMOD); end
               1: begin push_char(CLS_ZWJ); push_char(CLS_GAZ); end
               2: begin push_char(CLS_ZWJ); push_char(CLS_EBG); push_char(CLS_EMOD); end
               default: begin push_char(CLS_EBG); push_char(CLS_EMOD); push_char(CLS_EMOD); end
            endcase
         end
         5: for (k = 0; k < reps; k++) push_char(CLS_RI);
         6: begin
            case ($urandom_range(3))
               0:       begin push_char(CLS_CR); push_char(CLS_LF); end
               1:       push_char(CLS_CR);
               2:       push_char(CLS_LF);
               default: push_char(CLS_NL);
            endcase
         end
         7: begin
            case ($urandom_range(15))
               0:  cls = CLS_LET;
               1:  cls = CLS_NUMB;
               2:  cls = CLS_DQ;
               3:  cls = CLS_ML;
               4:  cls = CLS_MN;
               5:  cls = CLS_MNL;
               6:  cls = CLS_PUN;
               7:  cls = CLS_SQ;
               8:  cls = CLS_EMOD;
               9:  cls = CLS_GAZ;
               10: cls = CLS_SYM;
               11: cls = CLS_EXT;
               12: cls = CLS_MARK;
               13: cls = CLS_FMT;
               14: cls = CLS_OTH;
               default: cls = CLS_WS;
            endcase
            push_char(cls);
         end
         8: for (k = 0; k < reps; k++) push_char(5'($urandom_range(31)));
         default: push_char(CLS_WS);
      endcase
      if ($urandom_range(1)) push_char(CLS_WS);
      if ($urandom_range(6) == 0) text_chars[text_chars.size()-1].end_of_text = 1'b1;
   endfunction

   // Presents one character and waits for its transfer; predicts at the transfer edge
   task automatic send_char(input req_type c, input logic typed, input rsp_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_char(c);
      if (typed) expected_words.push_back(want);
      else foreach (step_words[k]) expected_words.push_back(step_words[k]);
   endtask

   task automatic send_text();
      rsp_type none;
      none = '0;
      while (text_chars.size() > 0) send_char(text_chars.pop_front(), 1'b0, none);
   endtask

   // Receiver stalls at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: length %0d type %0d last %0d",
                   rsp_data.word_length, rsp_data.word_type, rsp_data.last_word);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.word_length !== want.word_length) begin
               $error("word_length: expected %0d, actual %0d",
                      want.word_length, rsp_data.word_length);
               error_count++;
            end
            if (rsp_data.word_type !== want.word_type) begin
               $error("word_type: expected %0d, actual %0d", want.word_type, rsp_data.word_type);
               error_count++;
            end
            if (rsp_data.last_word !== want.last_word) begin
               $error("last_word: expected %0d, actual %0d", want.last_word, rsp_data.last_word);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      req_type c;
      rsp_type want;
      int phase;

      // Directed rows: class, bytes, end of text, typed, length, type
      drill_rows = '{
         '{CLS_LF,   3'd1, 1'b0, 1'b1, 16'd1, KIND_SPACE},  // newline right after reset
         '{CLS_CR,   3'd1, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_LF,   3'd1, 1'b0, 1'b1, 16'd2, KIND_SPACE},  // CR LF stays together
         '{CLS_EXT,  3'd3, 1'b0, 1'b0, 16'd0, KIND_SPACE},  // extender opens a word
         '{CLS_WS,   3'd1, 1'b0, 1'b1, 16'd3, KIND_MARK},
         '{CLS_AL,   3'd7, 1'b0, 1'b1, 16'd1, KIND_SPACE},
         '{CLS_ML,   3'd2, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_AL,   3'd0, 1'b0, 1'b0, 16'd0, KIND_SPACE},  // zero-byte letter
         '{CLS_SQ,   3'd1, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_FMT,  3'd2, 1'b0, 1'b0, 16'd0, KIND_SPACE},  // absorbed into held quote
         '{CLS_NUM,  3'd5, 1'b0, 1'b0, 16'd0, KIND_SPACE},  // failed mid character
         '{CLS_MN,   3'd1, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_NUM,  3'd6, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_MNL,  3'd1, 1'b1, 1'b0, 16'd0, KIND_SPACE},  // flush with mid held
         '{CLS_HEB,  3'd2, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_SQ,   3'd1, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_CR,   3'd1, 1'b0, 1'b0, 16'd0, KIND_SPACE},  // Hebrew keeps its quote
         '{CLS_ZWJ,  3'd3, 1'b0, 1'b0, 16'd0, KIND_SPACE},  // extender after CR
         '{CLS_EBG,  3'd4, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_EMOD, 3'd4, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_RI,   3'd4, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_RI,   3'd4, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_KAT,  3'd3, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_ENL,  3'd3, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{CLS_NUM,  3'd1, 1'b0, 1'b0, 16'd0, KIND_SPACE},
         '{5'd31,    3'd7, 1'b1, 1'b0, 16'd0, KIND_SPACE}   // unknown class at end of text
      };

      send_idle_pct = 33;
      recv_idle_pct = 79;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (drill_rows[k]) begin
         c.break_class    = drill_rows[k].cls;
         c.char_bytes     = drill_rows[k].bytes;
         c.end_of_text    = drill_rows[k].eot;
         want.word_length = drill_rows[k].len;
         want.word_type   = drill_rows[k].kind;
         want.last_word   = drill_rows[k].eot;
         send_char(c, drill_rows[k].typed, want);
      end

      // Random text under three idling patterns
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 33; recv_idle_pct = 79; end
            1:       begin send_idle_pct = 79; recv_idle_pct = 33; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         while (text_chars.size() < 50) add_fragment();
         text_chars[text_chars.size()-1].end_of_text = 1'b1;
         send_text();
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
